// File: src/pces_pkg.sv
// shared types and constants for the pixel channel extract and scale block
package pces_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int CHAN_W       = 16;
    localparam int FRAC_BITS    = 16;
    localparam int CFG_DATA_W   = 24;
    localparam int SUM_W        = 18;

    localparam logic [2:0]        AVG_SELECT = 3'd4;
    localparam logic [2:0]        CNT_MAX    = 3'(MAX_CHANNELS);
    localparam logic [CHAN_W-1:0] FS_NARROW  = 16'd255;
    localparam logic [CHAN_W-1:0] FS_WIDE    = 16'd65535;

    // reciprocal of 3 with 21 fraction bits, exact for sums below 2**21
    localparam int          DIV3_SHIFT = 21;
    localparam logic [19:0] DIV3_MUL   = 20'd699051;

    typedef enum logic [2:0] {
        REG_SOURCE_CHANNELS = 3'd0,
        REG_TARGET_CHANNELS = 3'd1,
        REG_SOURCE_WIDE     = 3'd2,
        REG_TARGET_WIDE     = 3'd3,
        REG_SOURCE_SELECT   = 3'd4,
        REG_TARGET_SLOT     = 3'd5,
        REG_GAIN            = 3'd6,
        REG_BIAS            = 3'd7
    } t_reg_index;

    typedef logic [MAX_CHANNELS-1:0][CHAN_W-1:0] t_chan_vec;

    typedef struct packed {
        logic [CHAN_W-1:0] src_c0;
        logic [CHAN_W-1:0] src_c1;
        logic [CHAN_W-1:0] src_c2;
        logic [CHAN_W-1:0] src_c3;
        logic [CHAN_W-1:0] dst_c0;
        logic [CHAN_W-1:0] dst_c1;
        logic [CHAN_W-1:0] dst_c2;
        logic [CHAN_W-1:0] dst_c3;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] out_c0;
        logic [CHAN_W-1:0] out_c1;
        logic [CHAN_W-1:0] out_c2;
        logic [CHAN_W-1:0] out_c3;
        logic              status;
    } t_out_beat;

    typedef struct packed {
        logic [2:0]         source_channels;
        logic [2:0]         target_channels;
        logic               source_wide;
        logic               target_wide;
        logic [2:0]         source_select;
        logic [1:0]         target_slot;
        logic signed [23:0] gain;
        logic signed [17:0] bias;
    } t_cfg;

    // value picked or averaged, carried from the select half to the scale half
    typedef struct packed {
        logic [CHAN_W-1:0] v;
        logic              bad;
        t_chan_vec         dst;
    } t_mid;

endpackage

// File: src/pces_cfg.sv
// configuration register file
module pces_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [pces_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pces_pkg::t_cfg                 o_cfg
);

    pces_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_channels <= 3'd4;
            r_cfg.target_channels <= 3'd4;
            r_cfg.source_wide     <= 1'b0;
            r_cfg.target_wide     <= 1'b0;
            r_cfg.source_select   <= 3'd0;
            r_cfg.target_slot     <= 2'd0;
            r_cfg.gain            <= 24'sd65536;
            r_cfg.bias            <= 18'sd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pces_pkg::REG_SOURCE_CHANNELS: r_cfg.source_channels <= i_cfg_data[2:0];
                pces_pkg::REG_TARGET_CHANNELS: r_cfg.target_channels <= i_cfg_data[2:0];
                pces_pkg::REG_SOURCE_WIDE:     r_cfg.source_wide     <= i_cfg_data[0];
                pces_pkg::REG_TARGET_WIDE:     r_cfg.target_wide     <= i_cfg_data[0];
                pces_pkg::REG_SOURCE_SELECT:   r_cfg.source_select   <= i_cfg_data[2:0];
                pces_pkg::REG_TARGET_SLOT:     r_cfg.target_slot     <= i_cfg_data[1:0];
                pces_pkg::REG_GAIN:            r_cfg.gain            <= i_cfg_data[23:0];
                pces_pkg::REG_BIAS:            r_cfg.bias            <= i_cfg_data[17:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// File: src/pces_avg.sv
// stages 1 and 2: config check, channel pick or sum, then divide by count
module pces_avg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pces_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  pces_pkg::t_in_beat i_beat,
    output logic               o_valid,
    input  logic               i_ready,
    output pces_pkg::t_mid     o_mid
);

    pces_pkg::t_chan_vec src;
    pces_pkg::t_chan_vec dst;
    logic                       n1_bad;
    logic                       n1_avg;
    logic [pces_pkg::SUM_W-1:0] n1_sum;

    logic                       r1_valid;
    logic                       r1_bad;
    logic                       r1_avg;
    logic [2:0]                 r1_cnt;
    logic [pces_pkg::SUM_W-1:0] r1_sum;
    pces_pkg::t_chan_vec        r1_dst;
    logic                       s1_ready;

    logic [37:0]                n2_q3;
    logic [pces_pkg::CHAN_W-1:0] n2_v;
    logic                       r2_valid;
    pces_pkg::t_mid             r2_mid;

    always_comb begin
        logic [pces_pkg::CHAN_W-1:0] smask;
        smask = i_cfg.source_wide ? pces_pkg::FS_WIDE : pces_pkg::FS_NARROW;
        src[0] = i_beat.src_c0 & smask;
        src[1] = i_beat.src_c1 & smask;
        src[2] = i_beat.src_c2 & smask;
        src[3] = i_beat.src_c3 & smask;
        dst[0] = i_beat.dst_c0;
        dst[1] = i_beat.dst_c1;
        dst[2] = i_beat.dst_c2;
        dst[3] = i_beat.dst_c3;
    end

    always_comb begin
        n1_bad = 1'b0;
        if (i_cfg.source_wide && !i_cfg.target_wide) begin
            n1_bad = 1'b1;
        end
        if (i_cfg.source_channels == 3'd0 || i_cfg.source_channels > pces_pkg::CNT_MAX) begin
            n1_bad = 1'b1;
        end
        if (i_cfg.target_channels == 3'd0 || i_cfg.target_channels > pces_pkg::CNT_MAX) begin
            n1_bad = 1'b1;
        end
        if ({1'b0, i_cfg.target_slot} >= i_cfg.target_channels) begin
            n1_bad = 1'b1;
        end
        if (i_cfg.source_select > pces_pkg::AVG_SELECT) begin
            n1_bad = 1'b1;
        end
        if (i_cfg.source_select < pces_pkg::AVG_SELECT
            && i_cfg.source_select >= i_cfg.source_channels) begin
            n1_bad = 1'b1;
        end
    end

    always_comb begin
        n1_avg = (i_cfg.source_select == pces_pkg::AVG_SELECT);
        n1_sum = '0;
        if (n1_avg) begin
            for (int c = 0; c < pces_pkg::MAX_CHANNELS; c++) begin
                if (3'(c) < i_cfg.source_channels) begin
                    n1_sum = n1_sum + pces_pkg::SUM_W'(src[c]);
                end
            end
        end else begin
            n1_sum = pces_pkg::SUM_W'(src[i_cfg.source_select[1:0]]);
        end
    end

    assign s1_ready = !r2_valid || i_ready;
    assign o_ready  = !r1_valid || s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (o_ready) begin
            r1_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r1_bad <= n1_bad;
            r1_avg <= n1_avg;
            r1_cnt <= i_cfg.source_channels;
            r1_sum <= n1_sum;
            r1_dst <= dst;
        end
    end

    // divide by the channel count: shifts, or a reciprocal multiply for three
    assign n2_q3 = {20'd0, r1_sum} * {18'd0, pces_pkg::DIV3_MUL};

    always_comb begin
        n2_v = r1_sum[15:0];
        if (r1_avg) begin
            case (r1_cnt)
                3'd2:    n2_v = r1_sum[16:1];
                3'd3:    n2_v = n2_q3[pces_pkg::DIV3_SHIFT +: pces_pkg::CHAN_W];
                3'd4:    n2_v = r1_sum[17:2];
                default: n2_v = r1_sum[15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s1_ready) begin
            r2_valid <= r1_valid;
        end
        if (s1_ready && r1_valid) begin
            r2_mid.v   <= n2_v;
            r2_mid.bad <= r1_bad;
            r2_mid.dst <= r1_dst;
        end
    end

    assign o_valid = r2_valid;
    assign o_mid   = r2_mid;

    a_avg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && !r1_bad && r1_avg |-> r1_cnt != 3'd0 && r1_cnt <= pces_pkg::CNT_MAX)
        else $error("average with a channel count out of range");

    a_narrow_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && !r2_mid.bad && !i_cfg.source_wide |-> r2_mid.v[15:8] == 8'd0)
        else $error("narrow source produced a value above 255");

endmodule

// File: src/pces_scale.sv
// stages 3 and 4: gain multiply and bias term, then sum, clamp and slot write
module pces_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pces_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  pces_pkg::t_mid      i_mid,
    output logic                o_valid,
    input  logic                i_ready,
    output pces_pkg::t_out_beat o_beat
);

    logic signed [16:0] n3_vs;
    logic signed [40:0] n3_prod;
    logic signed [34:0] n3_bext;
    logic signed [34:0] n3_bterm;

    logic                r3_valid;
    logic signed [40:0]  r3_prod;
    logic signed [34:0]  r3_bterm;
    logic                r3_bad;
    pces_pkg::t_chan_vec r3_dst;
    logic                s3_ready;

    logic signed [41:0]          n4_sum;
    logic [25:0]                 n4_q;
    logic [pces_pkg::CHAN_W-1:0] n4_fs;
    logic [pces_pkg::CHAN_W-1:0] n4_r;
    pces_pkg::t_chan_vec         n4_res;

    logic                r4_valid;
    pces_pkg::t_chan_vec r4_res;
    logic                r4_status;

    assign n3_vs   = $signed({1'b0, i_mid.v});
    assign n3_prod = i_cfg.gain * n3_vs;
    assign n3_bext = {{17{i_cfg.bias[17]}}, i_cfg.bias};
    // bias times full scale as shift and subtract
    assign n3_bterm = i_cfg.source_wide ? (n3_bext <<< 16) - n3_bext
                                        : (n3_bext <<< 8) - n3_bext;

    assign s3_ready = !r4_valid || i_ready;
    assign o_ready  = !r3_valid || s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (o_ready) begin
            r3_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r3_prod  <= n3_prod;
            r3_bterm <= n3_bterm;
            r3_bad   <= i_mid.bad;
            r3_dst   <= i_mid.dst;
        end
    end

    assign n4_sum = {r3_prod[40], r3_prod} + {{7{r3_bterm[34]}}, r3_bterm};
    assign n4_q   = n4_sum[41:pces_pkg::FRAC_BITS];
    assign n4_fs  = i_cfg.target_wide ? pces_pkg::FS_WIDE : pces_pkg::FS_NARROW;

    always_comb begin
        if (n4_sum <= 42'sd0) begin
            n4_r = '0;
        end else if (n4_q > {10'd0, n4_fs}) begin
            n4_r = n4_fs;
        end else begin
            n4_r = n4_q[15:0];
        end
        n4_res = r3_dst;
        if (!r3_bad) begin
            n4_res[i_cfg.target_slot] = n4_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (s3_ready) begin
            r4_valid <= r3_valid;
        end
        if (s3_ready && r3_valid) begin
            r4_res    <= n4_res;
            r4_status <= r3_bad;
        end
    end

    assign o_valid       = r4_valid;
    assign o_beat.out_c0 = r4_res[0];
    assign o_beat.out_c1 = r4_res[1];
    assign o_beat.out_c2 = r4_res[2];
    assign o_beat.out_c3 = r4_res[3];
    assign o_beat.status = r4_status;

    a_narrow_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && !r4_status && !i_cfg.target_wide
        |-> r4_res[i_cfg.target_slot][15:8] == 8'd0)
        else $error("narrow target written above 255");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid && s3_ready |=> r4_valid)
        else $error("beat lost between scale stages");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r3_valid && !r4_valid)
        else $error("scale stages hold a beat after reset");

endmodule

// File: src/pixel_channel_extract_scale_top.sv
// top level of the pixel channel extract and scale block
//
// Input channel: i_in_valid / o_in_ready carry one pixel per beat, the four
// source channels and the four existing target channels. Output channel:
// o_out_valid / i_out_ready carry the four result channels and a status bit
// (1 when the configuration is rejected and the target passes unchanged).
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write registers only while no beat is in flight.
//
// An accepted beat runs through select and check, divide by channel count,
// gain multiply, then sum and clamp to o_out_valid. One beat per cycle is
// sustained with i_out_ready high; the 24x17 gain multiply sets stage depth.
// Reset (synchronous, active low) empties all stages and loads the register
// defaults. When the receiver stalls, results stay held in the output stage
// and the stages behind it keep filling, so up to four beats are taken before
// o_in_ready drops; nothing is dropped or repeated.
module pixel_channel_extract_scale_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pces_pkg::t_in_beat              i_in_beat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pces_pkg::t_out_beat             o_out_beat,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [pces_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pces_pkg::t_cfg cfg;
    pces_pkg::t_mid mid;
    logic           mid_valid;
    logic           mid_ready;

    pces_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pces_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (i_in_beat),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    pces_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_mid   (mid),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

endmodule
